[design/wan_pkg.sv]
package wan_pkg;

   localparam int TIME_BITS_DEF = 40;
   localparam int SEARCH_DAYS   = 8;

   localparam int DAY_SECS      = 86400;
   localparam int WEEK_SECS     = 604800;
   localparam int HOUR_SECS     = 3600;
   localparam int MIN_SECS      = 60;
   localparam int DAYS_PER_WEEK = 7;
   localparam int EPOCH_WDAY    = 4;

   localparam int DIV_DIGIT = 4;
   localparam int REM_W     = 20;
   localparam int SOD_W     = 17;
   localparam int SSOD_W    = SOD_W + 2;
   localparam int WDAY_W    = 3;

   localparam int WAKE_W  = 41;
   localparam int UNTIL_W = 20;

   localparam int ENABLE_W = 1;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int MASK_W   = 7;
   localparam int ZONE_W   = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_WAKE_ENABLE  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAKE_HOUR    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAKE_MINUTE  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_WEEKDAY_MASK = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZONE_OFFSET  = 3'd4;

   localparam logic [HOUR_W-1:0] WAKE_HOUR_RST = 5'd8;
   localparam logic [MIN_W-1:0]  WAKE_MIN_RST  = 6'd0;
   localparam logic [MASK_W-1:0] MASK_RST      = 7'h7f;
   localparam logic [ZONE_W-1:0] ZONE_RST      = 5'b11000;

   // fold DIV_DIGIT bits of the time into the remainder modulo one week
   function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem,
                                                 input logic [DIV_DIGIT-1:0] digit);
      logic [REM_W:0]   x;
      logic [REM_W-1:0] r;
      r = rem;
      for (int j = 0; j < DIV_DIGIT; j++) begin
         x = {r, digit[DIV_DIGIT-1-j]};
         if (x >= (REM_W+1)'(WEEK_SECS)) begin
            x = x - (REM_W+1)'(WEEK_SECS);
         end
         r = x[REM_W-1:0];
      end
      return r;
   endfunction

endpackage

[design/weekly_alarm_next_wake.sv]
// The request word passes through the division stages, then the split, local-time, search and output
// registers; the week-remainder division takes one 4-bit digit a stage.
// Throughput: one word per cycle; every stage moves together when the output register is
// free or its word is being taken.
// Reset: synchronous, active high; clears the stage valid bits and restores the registers
// to enable 0, 08:00, all weekdays, offset -8 hours.
module weekly_alarm_next_wake #(
   parameter int TIME_BITS = wan_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [wan_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [wan_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [TIME_BITS-1:0]          req_now_seconds,
   input  logic                          req_time_valid,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wan_pkg::WAKE_W-1:0]    rsp_wake_time,
   output logic [wan_pkg::UNTIL_W-1:0]   rsp_seconds_until,
   output logic                          rsp_wake_ready
);
   import wan_pkg::*;

   localparam int ND    = (TIME_BITS + DIV_DIGIT - 1) / DIV_DIGIT;
   localparam int PAD_W = ND * DIV_DIGIT;
   localparam int SUM_W = (TIME_BITS + 1 > WAKE_W) ? TIME_BITS + 1 : WAKE_W;

   logic                wake_enable_ff;
   logic [HOUR_W-1:0]   wake_hour_ff;
   logic [MIN_W-1:0]    wake_minute_ff;
   logic [MASK_W-1:0]   weekday_mask_ff;
   logic [ZONE_W-1:0]   zone_offset_hours_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_enable_ff       <= 1'b0;
         wake_hour_ff         <= WAKE_HOUR_RST;
         wake_minute_ff       <= WAKE_MIN_RST;
         weekday_mask_ff      <= MASK_RST;
         zone_offset_hours_ff <= ZONE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WAKE_ENABLE:  wake_enable_ff       <= csr_data[ENABLE_W-1:0];
            CSR_WAKE_HOUR:    wake_hour_ff         <= csr_data[HOUR_W-1:0];
            CSR_WAKE_MINUTE:  wake_minute_ff       <= csr_data[MIN_W-1:0];
            CSR_WEEKDAY_MASK: weekday_mask_ff      <= csr_data[MASK_W-1:0];
            CSR_ZONE_OFFSET:  zone_offset_hours_ff <= csr_data[ZONE_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_vld_ff;

   assign adv       = !(out_vld_ff && rsp_stall);
   assign req_stall = !adv;

   logic live_in;
   assign live_in = req_time_valid && wake_enable_ff && (req_now_seconds != '0);

   // remainder of the time modulo one week, one digit a stage
   logic [REM_W-1:0]     div_rem_ff  [ND];
   logic [TIME_BITS-1:0] div_now_ff  [ND];
   logic                 div_vld_ff  [ND];
   logic                 div_live_ff [ND];

   genvar i;
   generate
      for (i = 0; i < ND; i++) begin : g_div
         logic [TIME_BITS-1:0] now_prev;
         logic [REM_W-1:0]     rem_prev;
         logic                 vld_prev;
         logic                 live_prev;
         logic [PAD_W-1:0]     pad;
         logic [REM_W-1:0]     rem_in;

         if (i == 0) begin : g_head
            assign now_prev  = req_now_seconds;
            assign rem_prev  = '0;
            assign vld_prev  = req_valid;
            assign live_prev = live_in;
         end else begin : g_body
            assign now_prev  = div_now_ff[i-1];
            assign rem_prev  = div_rem_ff[i-1];
            assign vld_prev  = div_vld_ff[i-1];
            assign live_prev = div_live_ff[i-1];
         end

         assign pad    = PAD_W'(now_prev);
         assign rem_in = rem_step(rem_prev, pad[PAD_W-1-DIV_DIGIT*i -: DIV_DIGIT]);

         always_ff @(posedge clock) begin
            if (reset) begin
               div_vld_ff[i] <= 1'b0;
            end else if (adv) begin
               div_vld_ff[i] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               div_rem_ff[i]  <= rem_in;
               div_now_ff[i]  <= now_prev;
               div_live_ff[i] <= live_prev;
            end
         end
      end
   endgenerate

   // split the week remainder into UTC weekday offset and second of day
   logic                 a_vld_ff;
   logic                 a_live_ff;
   logic [TIME_BITS-1:0] a_now_ff;
   logic [WDAY_W-1:0]    a_day_ff;
   logic [SOD_W-1:0]     a_sod_ff;
   logic [WDAY_W-1:0]    a_day_in;
   logic [SOD_W-1:0]     a_sod_in;

   always_comb begin
      a_day_in = '0;
      a_sod_in = SOD_W'(div_rem_ff[ND-1]);
      for (int j = 1; j < DAYS_PER_WEEK; j++) begin
         if (div_rem_ff[ND-1] >= REM_W'(j * DAY_SECS)) begin
            a_day_in = WDAY_W'(j);
            a_sod_in = SOD_W'(div_rem_ff[ND-1] - REM_W'(j * DAY_SECS));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= div_vld_ff[ND-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_live_ff <= div_live_ff[ND-1];
         a_now_ff  <= div_now_ff[ND-1];
         a_day_ff  <= a_day_in;
         a_sod_ff  <= a_sod_in;
      end
   end

   // shift to local time, find local weekday, form wake offset within a day
   logic                 b_vld_ff;
   logic                 b_live_ff;
   logic [TIME_BITS-1:0] b_now_ff;
   logic [WDAY_W-1:0]    b_wday_ff;
   logic [SOD_W-1:0]     b_sod_ff;
   logic [SOD_W-1:0]     b_base_ff;
   logic                 b_carry_ff;
   logic [WDAY_W-1:0]    b_wday_in;
   logic [SOD_W-1:0]     b_sod_in;
   logic [SOD_W-1:0]     b_base_in;
   logic                 b_carry_in;

   always_comb begin
      logic signed [SSOD_W-1:0] zone_ext;
      logic signed [SSOD_W-1:0] zone_secs;
      logic signed [SSOD_W-1:0] sod_raw;
      logic signed [SSOD_W-1:0] sod_fix;
      logic [WDAY_W:0]          wsum;
      zone_ext  = SSOD_W'($signed(zone_offset_hours_ff));
      zone_secs = zone_ext * SSOD_W'(HOUR_SECS);
      sod_raw   = $signed({2'b00, a_sod_ff}) + zone_secs;
      priority if (sod_raw < 0) begin
         sod_fix = sod_raw + SSOD_W'(DAY_SECS);
         wsum    = {1'b0, a_day_ff} + (WDAY_W+1)'(EPOCH_WDAY - 1);
      end else if (sod_raw >= SSOD_W'(DAY_SECS)) begin
         sod_fix = sod_raw - SSOD_W'(DAY_SECS);
         wsum    = {1'b0, a_day_ff} + (WDAY_W+1)'(EPOCH_WDAY + 1);
      end else begin
         sod_fix = sod_raw;
         wsum    = {1'b0, a_day_ff} + (WDAY_W+1)'(EPOCH_WDAY);
      end
      if (wsum >= (WDAY_W+1)'(DAYS_PER_WEEK)) begin
         wsum = wsum - (WDAY_W+1)'(DAYS_PER_WEEK);
      end
      b_sod_in   = sod_fix[SOD_W-1:0];
      b_wday_in  = wsum[WDAY_W-1:0];
      b_base_in  = SOD_W'(int'(wake_hour_ff) * HOUR_SECS + int'(wake_minute_ff) * MIN_SECS);
      b_carry_in = (b_base_in >= SOD_W'(DAY_SECS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_live_ff  <= a_live_ff;
         b_now_ff   <= a_now_ff;
         b_wday_ff  <= b_wday_in;
         b_sod_ff   <= b_sod_in;
         b_base_ff  <= b_base_in;
         b_carry_ff <= b_carry_in;
      end
   end

   // test the day candidates side by side, earliest wins
   logic                 c_vld_ff;
   logic                 c_hit_ff;
   logic [TIME_BITS-1:0] c_now_ff;
   logic [UNTIL_W-1:0]   c_delta_ff;
   logic                 c_found_in;
   logic [UNTIL_W-1:0]   c_delta_in;

   always_comb begin
      logic [REM_W-1:0]  t;
      logic [WDAY_W:0]   wd;
      c_found_in = 1'b0;
      c_delta_in = '0;
      for (int k = SEARCH_DAYS - 1; k >= 0; k--) begin
         t  = REM_W'(k * DAY_SECS) + REM_W'(b_base_ff);
         wd = {1'b0, b_wday_ff} + (WDAY_W+1)'(k) + (WDAY_W+1)'(b_carry_ff);
         if (wd >= (WDAY_W+1)'(DAYS_PER_WEEK)) begin
            wd = wd - (WDAY_W+1)'(DAYS_PER_WEEK);
         end
         if (wd >= (WDAY_W+1)'(DAYS_PER_WEEK)) begin
            wd = wd - (WDAY_W+1)'(DAYS_PER_WEEK);
         end
         if (weekday_mask_ff[wd[WDAY_W-1:0]] && (t > REM_W'(b_sod_ff))) begin
            c_found_in = 1'b1;
            c_delta_in = UNTIL_W'(t - REM_W'(b_sod_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_hit_ff   <= b_live_ff && c_found_in;
         c_now_ff   <= b_now_ff;
         c_delta_ff <= c_delta_in;
      end
   end

   // output register: add the offset to now, zero the word when the request is not live or nothing was found
   logic [WAKE_W-1:0]  out_wake_ff;
   logic [UNTIL_W-1:0] out_until_ff;
   logic               out_ready_ff;
   logic [SUM_W-1:0]   wake_sum;

   assign wake_sum = SUM_W'(c_now_ff) + SUM_W'(c_delta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (c_hit_ff) begin
            out_wake_ff  <= wake_sum[WAKE_W-1:0];
            out_until_ff <= c_delta_ff;
            out_ready_ff <= 1'b1;
         end else begin
            out_wake_ff  <= '0;
            out_until_ff <= '0;
            out_ready_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_wake_time     = out_wake_ff;
   assign rsp_seconds_until = out_until_ff;
   assign rsp_wake_ready    = out_ready_ff;

endmodule
